// ----- rtl/pft_pkg.sv -----
package pft_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int FRACTION_BITS = 16;

   localparam int IDX_W    = 5;
   localparam int CORDIC_W = 34;
   localparam int Z_W      = 33;
   localparam int OP_W     = 33;
   localparam int CS_W     = FRACTION_BITS + 2;
   localparam int PROD_W   = OP_W + CS_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int FIN_W    = SUM_W + 1;

   localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = CORDIC_W'(652032874);
   localparam logic signed [31:0] QUARTER_TURN = 32'sh40000000;
   localparam logic signed [31:0] NEG_QUARTER_TURN = 32'shC0000000;
   localparam logic signed [CORDIC_W-1:0] COEF_BIAS = CORDIC_W'(1) << (29 - FRACTION_BITS);
   localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (FRACTION_BITS - 1);
   localparam logic signed [FIN_W-1:0] RESULT_MAX = FIN_W'(2147483647);
   localparam logic signed [FIN_W-1:0] RESULT_MIN = ~RESULT_MAX;

   typedef enum logic {
      MODE_TO_LOCAL = 1'b0,
      MODE_TO_WORLD = 1'b1
   } mode_type;

   typedef struct packed {
      logic                   mode;
      logic signed [OP_W-1:0] a;
      logic signed [OP_W-1:0] b;
      logic signed [31:0]     off_x;
      logic signed [31:0]     off_y;
   } operand_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [Z_W-1:0]      z;
      logic                       flip;
   } rotor_type;

   typedef struct packed {
      logic signed [CS_W-1:0] c;
      logic signed [CS_W-1:0] t;
   } coef_type;

   function automatic logic [31:0] atan_turn(input logic [IDX_W-1:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:  val = 32'h20000000;
         5'd1:  val = 32'h12E4051E;
         5'd2:  val = 32'h09FB385B;
         5'd3:  val = 32'h051111D4;
         5'd4:  val = 32'h028B0D43;
         5'd5:  val = 32'h0145D7E1;
         5'd6:  val = 32'h00A2F61E;
         5'd7:  val = 32'h00517C55;
         5'd8:  val = 32'h0028BE53;
         5'd9:  val = 32'h00145F2F;
         5'd10: val = 32'h000A2F98;
         5'd11: val = 32'h000517CC;
         5'd12: val = 32'h00028BE6;
         5'd13: val = 32'h000145F3;
         5'd14: val = 32'h0000A2FA;
         5'd15: val = 32'h0000517D;
         5'd16: val = 32'h000028BE;
         5'd17: val = 32'h0000145F;
         5'd18: val = 32'h00000A30;
         5'd19: val = 32'h00000518;
         5'd20: val = 32'h0000028C;
         5'd21: val = 32'h00000146;
         5'd22: val = 32'h000000A3;
         5'd23: val = 32'h00000051;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/pft_req_if.sv -----
interface pft_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [15:0] heading;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;

   modport source (output valid, mode, origin_x, origin_y, heading, point_x, point_y,
                   input ready);
   modport sink (input valid, mode, origin_x, origin_y, heading, point_x, point_y,
                 output ready);
endinterface

// ----- rtl/pft_rsp_if.sv -----
interface pft_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_x;
   logic signed [31:0] result_y;
   logic               saturated;

   modport source (output valid, result_x, result_y, saturated, input ready);
   modport sink (input valid, result_x, result_y, saturated, output ready);
endinterface

// ----- rtl/pft_prep.sv -----
module pft_prep (
   input  logic                  clock,
   input  logic                  reset,
   pft_req_if.sink               req_if,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output pft_pkg::rotor_type    dn_rotor,
   output pft_pkg::operand_type  dn_oper
);

   logic                  valid_ff;
   logic                  up_ready;
   pft_pkg::rotor_type    rotor_ff, rotor_in;
   pft_pkg::operand_type  oper_ff, oper_in;
   logic signed [31:0]    ang;
   logic signed [31:0]    red;
   logic                  wrap;

   assign up_ready = !valid_ff || dn_ready;
   assign req_if.ready = up_ready;

   always_comb begin
      ang  = {req_if.heading, 16'h0000};
      wrap = (ang > pft_pkg::QUARTER_TURN) || (ang < pft_pkg::NEG_QUARTER_TURN);
      red  = wrap ? {~ang[31], ang[30:0]} : ang;
      rotor_in.x    = pft_pkg::GAIN_Q30;
      rotor_in.y    = '0;
      rotor_in.z    = pft_pkg::Z_W'(red);
      rotor_in.flip = wrap;

      oper_in.mode = req_if.mode;
      if (req_if.mode == pft_pkg::MODE_TO_LOCAL) begin
         oper_in.a = pft_pkg::OP_W'(req_if.point_x) - pft_pkg::OP_W'(req_if.origin_x);
         oper_in.b = pft_pkg::OP_W'(req_if.point_y) - pft_pkg::OP_W'(req_if.origin_y);
         oper_in.off_x = '0;
         oper_in.off_y = '0;
      end else begin
         oper_in.a = pft_pkg::OP_W'(req_if.point_x);
         oper_in.b = pft_pkg::OP_W'(req_if.point_y);
         oper_in.off_x = req_if.origin_x;
         oper_in.off_y = req_if.origin_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && req_if.valid) begin
         rotor_ff <= rotor_in;
         oper_ff  <= oper_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rotor = rotor_ff;
   assign dn_oper  = oper_ff;

endmodule

// ----- rtl/pft_cordic_stage.sv -----
module pft_cordic_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pft_pkg::IDX_W-1:0]     shift,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  pft_pkg::rotor_type            up_rotor,
   input  pft_pkg::operand_type          up_oper,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output pft_pkg::rotor_type            dn_rotor,
   output pft_pkg::operand_type          dn_oper
);

   logic                                 valid_ff;
   pft_pkg::rotor_type                   rotor_ff, rotor_in;
   pft_pkg::operand_type                 oper_ff;
   logic signed [pft_pkg::CORDIC_W-1:0]  x, y, xs, ys;
   logic signed [pft_pkg::Z_W-1:0]       z, atan;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      x    = up_rotor.x;
      y    = up_rotor.y;
      z    = up_rotor.z;
      xs   = x >>> shift;
      ys   = y >>> shift;
      atan = pft_pkg::Z_W'(pft_pkg::atan_turn(shift));
      rotor_in.flip = up_rotor.flip;
      if (!z[pft_pkg::Z_W-1]) begin
         rotor_in.x = x - ys;
         rotor_in.y = y + xs;
         rotor_in.z = z - atan;
      end else begin
         rotor_in.x = x + ys;
         rotor_in.y = y - xs;
         rotor_in.z = z + atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         rotor_ff <= rotor_in;
         oper_ff  <= up_oper;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rotor = rotor_ff;
   assign dn_oper  = oper_ff;

endmodule

// ----- rtl/pft_coef.sv -----
module pft_coef (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  pft_pkg::rotor_type    up_rotor,
   input  pft_pkg::operand_type  up_oper,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output pft_pkg::coef_type     dn_coef,
   output pft_pkg::operand_type  dn_oper
);

   logic                                 valid_ff;
   pft_pkg::coef_type                    coef_ff, coef_in;
   pft_pkg::operand_type                 oper_ff;
   logic signed [pft_pkg::CORDIC_W-1:0]  xr, yr;
   logic signed [pft_pkg::CS_W-1:0]      c, s;

   assign up_ready = !valid_ff || dn_ready;

   // The sine term is negated once for the half-turn fold and once more for
   // local-to-world, so the two cancel when both apply.
   always_comb begin
      xr = (up_rotor.x + pft_pkg::COEF_BIAS) >>> (30 - pft_pkg::FRACTION_BITS);
      yr = (up_rotor.y + pft_pkg::COEF_BIAS) >>> (30 - pft_pkg::FRACTION_BITS);
      c  = pft_pkg::CS_W'(xr);
      s  = pft_pkg::CS_W'(yr);
      coef_in.c = up_rotor.flip ? -c : c;
      coef_in.t = (up_rotor.flip ^ up_oper.mode) ? -s : s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         coef_ff <= coef_in;
         oper_ff <= up_oper;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_coef  = coef_ff;
   assign dn_oper  = oper_ff;

endmodule

// ----- rtl/pft_mac.sv -----
module pft_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  pft_pkg::coef_type     up_coef,
   input  pft_pkg::operand_type  up_oper,
   pft_rsp_if.source             rsp_if
);

   logic                                 prod_valid_ff, sum_valid_ff, out_valid_ff;
   logic                                 prod_ready, sum_ready, out_ready;
   logic signed [pft_pkg::OP_W-1:0]      a, b;
   logic signed [pft_pkg::CS_W-1:0]      c, t;
   logic signed [pft_pkg::PROD_W-1:0]    ac_in, bt_in, bc_in, at_in;
   logic signed [pft_pkg::PROD_W-1:0]    ac_ff, bt_ff, bc_ff, at_ff;
   logic signed [31:0]                   prod_off_x_ff, prod_off_y_ff;
   logic signed [pft_pkg::SUM_W-1:0]     sum_x, sum_y;
   logic signed [pft_pkg::SUM_W-1:0]     rx_in, ry_in, rx_ff, ry_ff;
   logic signed [31:0]                   sum_off_x_ff, sum_off_y_ff;
   logic signed [pft_pkg::FIN_W-1:0]     fx, fy;
   logic signed [31:0]                   result_x_in, result_y_in;
   logic signed [31:0]                   result_x_ff, result_y_ff;
   logic                                 sat_x, sat_y, saturated_ff;

   assign out_ready  = !out_valid_ff || rsp_if.ready;
   assign sum_ready  = !sum_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || sum_ready;
   assign up_ready   = prod_ready;

   always_comb begin
      a = up_oper.a;
      b = up_oper.b;
      c = up_coef.c;
      t = up_coef.t;
      ac_in = a * c;
      bt_in = b * t;
      bc_in = b * c;
      at_in = a * t;
   end

   always_comb begin
      sum_x = pft_pkg::SUM_W'(ac_ff) + pft_pkg::SUM_W'(bt_ff);
      sum_y = pft_pkg::SUM_W'(bc_ff) - pft_pkg::SUM_W'(at_ff);
      rx_in = (sum_x + pft_pkg::ROUND_BIAS) >>> pft_pkg::FRACTION_BITS;
      ry_in = (sum_y + pft_pkg::ROUND_BIAS) >>> pft_pkg::FRACTION_BITS;
   end

   always_comb begin
      fx = pft_pkg::FIN_W'(rx_ff) + pft_pkg::FIN_W'(sum_off_x_ff);
      fy = pft_pkg::FIN_W'(ry_ff) + pft_pkg::FIN_W'(sum_off_y_ff);
      sat_x = (fx > pft_pkg::RESULT_MAX) || (fx < pft_pkg::RESULT_MIN);
      sat_y = (fy > pft_pkg::RESULT_MAX) || (fy < pft_pkg::RESULT_MIN);
      if (fx > pft_pkg::RESULT_MAX) begin
         result_x_in = 32'sh7FFFFFFF;
      end else if (fx < pft_pkg::RESULT_MIN) begin
         result_x_in = 32'sh80000000;
      end else begin
         result_x_in = fx[31:0];
      end
      if (fy > pft_pkg::RESULT_MAX) begin
         result_y_in = 32'sh7FFFFFFF;
      end else if (fy < pft_pkg::RESULT_MIN) begin
         result_y_in = 32'sh80000000;
      end else begin
         result_y_in = fy[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= up_valid;
         end
         if (sum_ready) begin
            sum_valid_ff <= prod_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= sum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && up_valid) begin
         ac_ff <= ac_in;
         bt_ff <= bt_in;
         bc_ff <= bc_in;
         at_ff <= at_in;
         prod_off_x_ff <= up_oper.off_x;
         prod_off_y_ff <= up_oper.off_y;
      end
      if (sum_ready && prod_valid_ff) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         sum_off_x_ff <= prod_off_x_ff;
         sum_off_y_ff <= prod_off_y_ff;
      end
      if (out_ready && sum_valid_ff) begin
         result_x_ff  <= result_x_in;
         result_y_ff  <= result_y_in;
         saturated_ff <= sat_x || sat_y;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.result_x  = result_x_ff;
   assign rsp_if.result_y  = result_y_ff;
   assign rsp_if.saturated = saturated_ff;

endmodule

// ----- rtl/planar_frame_transform.sv -----
// Planar frame transform: maps a point between a world frame and the local
// frame of a pose given by origin and heading, in Q16.16 fixed point.
// A request beat on req_if carries the mode, the pose and the point; mode 0
// maps a world point into the local frame and mode 1 maps it back. A
// response beat on rsp_if carries the two coordinates and a flag that is set
// when either of them was clamped to the signed 32-bit range.
// Each beat passes one operand stage, one CORDIC stage per iteration (16),
// one coefficient stage and three multiply, round and clamp stages, all
// registered, on its way from req_if to rsp_if.
// One beat is accepted every cycle while rsp_if is not stalled; the rate is set
// by the unrolled CORDIC pipeline, which holds one beat in each of its stages.
// Each stage holds its beat while the stage after it is full and stalled, so
// a stall on rsp_if fills the empty stages first and then drops req_if.ready;
// nothing is lost or repeated. Synchronous reset empties every stage; no
// other state is kept between beats.
module planar_frame_transform (
   input  logic      clock,
   input  logic      reset,
   pft_req_if.sink   req_if,
   pft_rsp_if.source rsp_if
);

   logic                  stage_valid [pft_pkg::CORDIC_STAGES+1];
   logic                  stage_ready [pft_pkg::CORDIC_STAGES+1];
   pft_pkg::rotor_type    stage_rotor [pft_pkg::CORDIC_STAGES+1];
   pft_pkg::operand_type  stage_oper  [pft_pkg::CORDIC_STAGES+1];
   logic                  coef_valid;
   logic                  coef_ready;
   pft_pkg::coef_type     coef;
   pft_pkg::operand_type  coef_oper;

   pft_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .dn_valid (stage_valid[0]),
      .dn_ready (stage_ready[0]),
      .dn_rotor (stage_rotor[0]),
      .dn_oper  (stage_oper[0])
   );

   for (genvar g = 0; g < pft_pkg::CORDIC_STAGES; g++) begin : g_cordic
      pft_cordic_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .shift    (pft_pkg::IDX_W'(g)),
         .up_valid (stage_valid[g]),
         .up_ready (stage_ready[g]),
         .up_rotor (stage_rotor[g]),
         .up_oper  (stage_oper[g]),
         .dn_valid (stage_valid[g+1]),
         .dn_ready (stage_ready[g+1]),
         .dn_rotor (stage_rotor[g+1]),
         .dn_oper  (stage_oper[g+1])
      );
   end

   pft_coef u_coef (
      .clock    (clock),
      .reset    (reset),
      .up_valid (stage_valid[pft_pkg::CORDIC_STAGES]),
      .up_ready (stage_ready[pft_pkg::CORDIC_STAGES]),
      .up_rotor (stage_rotor[pft_pkg::CORDIC_STAGES]),
      .up_oper  (stage_oper[pft_pkg::CORDIC_STAGES]),
      .dn_valid (coef_valid),
      .dn_ready (coef_ready),
      .dn_coef  (coef),
      .dn_oper  (coef_oper)
   );

   pft_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .up_valid (coef_valid),
      .up_ready (coef_ready),
      .up_coef  (coef),
      .up_oper  (coef_oper),
      .rsp_if   (rsp_if)
   );

endmodule
